// ----- design/im2col_address_generator_unit_assert.svh -----
// Assertion macros for the im2col address generator port checker.
`ifndef IM2COL_ADDRESS_GENERATOR_UNIT_ASSERT_SVH
`define IM2COL_ADDRESS_GENERATOR_UNIT_ASSERT_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define IAGU_CHECK(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("im2col agu: check failed");

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define IAGU_CHECK_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("im2col agu: check failed");

`endif

// ----- design/i2c_pkg.sv -----
// Shared types and constants of the im2col address generator.
`timescale 1ns / 1ps

package i2c_pkg;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;
  localparam int OUT_OFF_W  = 32;

  // counter widths
  localparam int ROW_W  = 16;
  localparam int KER_W  = 6;
  localparam int DIDX_W = 8;

  // bounded counts
  localparam logic [8:0] DV_MAX = 9'd256;
  localparam logic [6:0] KER_MAX = 7'd64;

  // register reset values
  localparam logic [8:0]  RST_DEPTH_VECS = 9'd1;
  localparam logic [6:0]  RST_KERNEL_W   = 7'd1;
  localparam logic [6:0]  RST_KERNEL_H   = 7'd1;
  localparam logic [15:0] RST_KRP        = 16'd1;
  localparam logic [31:0] RST_SRP        = 32'd0;
  localparam logic [31:0] RST_DRP        = 32'd0;
  localparam logic [31:0] RST_OUT_DIMS   = 32'h0001_0001;
  localparam logic [15:0] RST_STRIDES    = 16'h0101;

  // queue between front and back
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = 1;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_DEPTH_VECS,
    REG_KERNEL_W,
    REG_KERNEL_H,
    REG_KERNEL_ROW_PITCH,
    REG_SRC_ROW_PITCH,
    REG_DST_ROW_PITCH,
    REG_OUT_DIMS,
    REG_STRIDES
  } reg_idx_t;

  // clamped, unpacked configuration
  typedef struct packed {
    logic [8:0]  dv;
    logic [6:0]  kw;
    logic [6:0]  kh;
    logic [15:0] krp;
    logic [31:0] srp;
    logic [31:0] drp;
    logic [15:0] ow;
    logic [15:0] oh;
    logic [7:0]  sx;
    logic [7:0]  sy;
  } cfg_t;

endpackage

// ----- design/i2c_cfg.sv -----
// Configuration register file with count clamping.
`timescale 1ns / 1ps

module i2c_cfg (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [i2c_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [i2c_pkg::CFG_DATA_W-1:0]  cfg_data,
  output i2c_pkg::cfg_t                   cfg,
  output logic                            cfg_wr
);
  import i2c_pkg::*;

  logic [8:0]  depth_vecs_r;
  logic [6:0]  kernel_w_r;
  logic [6:0]  kernel_h_r;
  logic [15:0] krp_r;
  logic [31:0] srp_r;
  logic [31:0] drp_r;
  logic [31:0] out_dims_r;
  logic [15:0] strides_r;

  assign cfg_ready = 1'b1;
  assign cfg_wr    = cfg_valid && cfg_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      depth_vecs_r <= RST_DEPTH_VECS;
      kernel_w_r   <= RST_KERNEL_W;
      kernel_h_r   <= RST_KERNEL_H;
      krp_r        <= RST_KRP;
      srp_r        <= RST_SRP;
      drp_r        <= RST_DRP;
      out_dims_r   <= RST_OUT_DIMS;
      strides_r    <= RST_STRIDES;
    end else if (cfg_wr) begin
      unique case (reg_idx_t'(cfg_index))
        REG_DEPTH_VECS:       depth_vecs_r <= cfg_data[8:0];
        REG_KERNEL_W:         kernel_w_r   <= cfg_data[6:0];
        REG_KERNEL_H:         kernel_h_r   <= cfg_data[6:0];
        REG_KERNEL_ROW_PITCH: krp_r        <= cfg_data[15:0];
        REG_SRC_ROW_PITCH:    srp_r        <= cfg_data;
        REG_DST_ROW_PITCH:    drp_r        <= cfg_data;
        REG_OUT_DIMS:         out_dims_r   <= cfg_data;
        REG_STRIDES:          strides_r    <= cfg_data[15:0];
      endcase
    end
  end

  // zero counts as one, oversized counts saturate
  always_comb begin
    cfg = '0;
    if (depth_vecs_r == 9'd0)       cfg.dv = 9'd1;
    else if (depth_vecs_r > DV_MAX) cfg.dv = DV_MAX;
    else                            cfg.dv = depth_vecs_r;
    if (kernel_w_r == 7'd0)         cfg.kw = 7'd1;
    else if (kernel_w_r > KER_MAX)  cfg.kw = KER_MAX;
    else                            cfg.kw = kernel_w_r;
    if (kernel_h_r == 7'd0)         cfg.kh = 7'd1;
    else if (kernel_h_r > KER_MAX)  cfg.kh = KER_MAX;
    else                            cfg.kh = kernel_h_r;
    cfg.ow  = (out_dims_r[15:0] == 16'd0) ? 16'd1 : out_dims_r[15:0];
    cfg.oh  = (out_dims_r[31:16] == 16'd0) ? 16'd1 : out_dims_r[31:16];
    cfg.krp = krp_r;
    cfg.srp = srp_r;
    cfg.drp = drp_r;
    cfg.sx  = strides_r[7:0];
    cfg.sy  = strides_r[15:8];
  end

endmodule

// ----- design/i2c_front.sv -----
// Front end: position counters, incremental offset terms, rebuild sequencer.
`timescale 1ns / 1ps

module i2c_front #(
  parameter int AW = 32
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  i2c_pkg::cfg_t                  cfg,
  input  logic                           cfg_wr,
  input  logic                           in_push,
  input  logic                           in_restart,
  output logic                           in_full,
  input  logic                           q_full,
  output logic                           q_wr,
  output logic [5*AW+i2c_pkg::DIDX_W:0]  q_wdata
);
  import i2c_pkg::*;

  typedef enum logic [3:0] {
    SEQ_IDLE,
    SEQ_SY,
    SEQ_SX,
    SEQ_OW,
    SEQ_KRP,
    SEQ_RSRC,
    SEQ_KRSRC,
    SEQ_CSRC,
    SEQ_RDST,
    SEQ_KRDST,
    SEQ_CDST,
    SEQ_KC
  } seq_t;

  seq_t seq_r, seq_nxt;

  logic [ROW_W-1:0]  r_r, r_nxt, c_r, c_nxt;
  logic [KER_W-1:0]  kr_r, kr_nxt, kc_r, kc_nxt;
  logic [DIDX_W-1:0] d_r, d_nxt;

  logic [AW-1:0] src_rbase_r, src_rbase_nxt, src_row_r, src_row_nxt, src_col_r, src_col_nxt;
  logic [AW-1:0] dst_rbase_r, dst_rbase_nxt, dst_row_r, dst_row_nxt, dst_col_r, dst_col_nxt;
  logic [AW-1:0] kc_acc_r, kc_acc_nxt;
  logic [AW-1:0] step_sy_r, step_sy_nxt, step_sx_r, step_sx_nxt;
  logic [AW-1:0] step_ow_r, step_ow_nxt, step_krp_r, step_krp_nxt;

  logic [AW-1:0]    pix, srp, drp;
  logic [15:0]      mul_a;
  logic [AW-1:0]    mul_b;
  logic [AW+15:0]   prod_full;
  logic [AW-1:0]    prod;
  logic             busy, accept;

  // effective position after an optional restart
  logic [ROW_W-1:0]  e_r, e_c;
  logic [KER_W-1:0]  e_kr, e_kc;
  logic [DIDX_W-1:0] e_d;
  logic [AW-1:0]     e_src_rbase, e_src_row, e_src_col;
  logic [AW-1:0]     e_dst_rbase, e_dst_row, e_dst_col, e_kc_acc;
  logic              e_last;

  logic [DIDX_W:0] d_inc;
  logic [KER_W:0]  kc_inc, kr_inc;
  logic [ROW_W:0]  c_inc, r_inc;
  logic            d_wrap, kc_wrap, c_wrap, kr_wrap, r_wrap;

  assign pix  = AW'({cfg.dv, 2'b00});
  assign srp  = cfg.srp[AW-1:0];
  assign drp  = cfg.drp[AW-1:0];

  assign busy    = (seq_r != SEQ_IDLE);
  assign in_full = busy || q_full;
  assign accept  = in_push && !in_full;
  assign q_wr    = accept;

  // shared multiplier for the rebuild pass
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (seq_r)
      SEQ_IDLE:  begin mul_a = '0;           mul_b = '0;         end
      SEQ_SY:    begin mul_a = 16'(cfg.sy);  mul_b = srp;        end
      SEQ_SX:    begin mul_a = 16'(cfg.sx);  mul_b = pix;        end
      SEQ_OW:    begin mul_a = cfg.ow;       mul_b = drp;        end
      SEQ_KRP:   begin mul_a = cfg.krp;      mul_b = pix;        end
      SEQ_RSRC:  begin mul_a = r_r;          mul_b = step_sy_r;  end
      SEQ_KRSRC: begin mul_a = 16'(kr_r);    mul_b = srp;        end
      SEQ_CSRC:  begin mul_a = c_r;          mul_b = step_sx_r;  end
      SEQ_RDST:  begin mul_a = r_r;          mul_b = step_ow_r;  end
      SEQ_KRDST: begin mul_a = 16'(kr_r);    mul_b = step_krp_r; end
      SEQ_CDST:  begin mul_a = c_r;          mul_b = drp;        end
      SEQ_KC:    begin mul_a = 16'(kc_r);    mul_b = pix;        end
    endcase
  end

  assign prod_full = mul_a * mul_b;
  assign prod      = prod_full[AW-1:0];

  // position and terms of the emitted vector
  always_comb begin
    e_r = r_r;  e_c = c_r;  e_kr = kr_r;  e_kc = kc_r;  e_d = d_r;
    e_src_rbase = src_rbase_r;  e_src_row = src_row_r;  e_src_col = src_col_r;
    e_dst_rbase = dst_rbase_r;  e_dst_row = dst_row_r;  e_dst_col = dst_col_r;
    e_kc_acc = kc_acc_r;
    if (in_restart) begin
      e_r = '0;  e_c = '0;  e_kr = '0;  e_kc = '0;  e_d = '0;
      e_src_rbase = '0;  e_src_row = '0;  e_src_col = '0;
      e_dst_rbase = '0;  e_dst_row = '0;  e_dst_col = '0;
      e_kc_acc = '0;
    end
  end

  assign e_last = (e_r == cfg.oh - 16'd1) && ({1'b0, e_kr} == cfg.kh - 7'd1)
                  && (e_c == cfg.ow - 16'd1) && ({1'b0, e_kc} == cfg.kw - 7'd1)
                  && ({1'b0, e_d} == cfg.dv - 9'd1);

  assign q_wdata = {e_last, e_d, e_kc_acc, e_dst_col, e_dst_row, e_src_col, e_src_row};

  assign d_inc   = {1'b0, e_d} + 9'd1;
  assign kc_inc  = {1'b0, e_kc} + 7'd1;
  assign kr_inc  = {1'b0, e_kr} + 7'd1;
  assign c_inc   = {1'b0, e_c} + 17'd1;
  assign r_inc   = {1'b0, e_r} + 17'd1;
  assign d_wrap  = d_inc >= cfg.dv;
  assign kc_wrap = kc_inc >= cfg.kw;
  assign kr_wrap = kr_inc >= cfg.kh;
  assign c_wrap  = c_inc >= {1'b0, cfg.ow};
  assign r_wrap  = r_inc >= {1'b0, cfg.oh};

  always_comb begin
    seq_nxt = seq_r;
    r_nxt = r_r;  c_nxt = c_r;  kr_nxt = kr_r;  kc_nxt = kc_r;  d_nxt = d_r;
    src_rbase_nxt = src_rbase_r;  src_row_nxt = src_row_r;  src_col_nxt = src_col_r;
    dst_rbase_nxt = dst_rbase_r;  dst_row_nxt = dst_row_r;  dst_col_nxt = dst_col_r;
    kc_acc_nxt = kc_acc_r;
    step_sy_nxt = step_sy_r;  step_sx_nxt = step_sx_r;
    step_ow_nxt = step_ow_r;  step_krp_nxt = step_krp_r;

    // rebuild pass: steps first, then every term from the live counters
    unique case (seq_r)
      SEQ_IDLE:  seq_nxt = SEQ_IDLE;
      SEQ_SY:    begin step_sy_nxt = prod;  seq_nxt = SEQ_SX;  end
      SEQ_SX:    begin step_sx_nxt = prod;  seq_nxt = SEQ_OW;  end
      SEQ_OW:    begin step_ow_nxt = prod;  seq_nxt = SEQ_KRP; end
      SEQ_KRP:   begin step_krp_nxt = prod; seq_nxt = SEQ_RSRC; end
      SEQ_RSRC:  begin
        src_rbase_nxt = prod;
        src_row_nxt   = prod;
        seq_nxt       = SEQ_KRSRC;
      end
      SEQ_KRSRC: begin src_row_nxt = src_row_r + prod; seq_nxt = SEQ_CSRC; end
      SEQ_CSRC:  begin src_col_nxt = prod;             seq_nxt = SEQ_RDST; end
      SEQ_RDST:  begin
        dst_rbase_nxt = prod;
        dst_row_nxt   = prod;
        seq_nxt       = SEQ_KRDST;
      end
      SEQ_KRDST: begin dst_row_nxt = dst_row_r + prod; seq_nxt = SEQ_CDST; end
      SEQ_CDST:  begin dst_col_nxt = prod;             seq_nxt = SEQ_KC;   end
      SEQ_KC:    begin kc_acc_nxt = prod;              seq_nxt = SEQ_IDLE; end
    endcase

    // advance: depth, kernel column, output column, kernel row, output row
    if (accept) begin
      r_nxt = e_r;  c_nxt = e_c;  kr_nxt = e_kr;  kc_nxt = e_kc;
      src_rbase_nxt = e_src_rbase;  src_row_nxt = e_src_row;  src_col_nxt = e_src_col;
      dst_rbase_nxt = e_dst_rbase;  dst_row_nxt = e_dst_row;  dst_col_nxt = e_dst_col;
      kc_acc_nxt = e_kc_acc;
      if (!d_wrap) begin
        d_nxt = d_inc[DIDX_W-1:0];
      end else begin
        d_nxt = '0;
        if (!kc_wrap) begin
          kc_nxt     = kc_inc[KER_W-1:0];
          kc_acc_nxt = e_kc_acc + pix;
        end else begin
          kc_nxt     = '0;
          kc_acc_nxt = '0;
          if (!c_wrap) begin
            c_nxt       = c_inc[ROW_W-1:0];
            src_col_nxt = e_src_col + step_sx_r;
            dst_col_nxt = e_dst_col + drp;
          end else begin
            c_nxt       = '0;
            src_col_nxt = '0;
            dst_col_nxt = '0;
            if (!kr_wrap) begin
              kr_nxt      = kr_inc[KER_W-1:0];
              src_row_nxt = e_src_row + srp;
              dst_row_nxt = e_dst_row + step_krp_r;
            end else begin
              kr_nxt = '0;
              if (!r_wrap) begin
                r_nxt         = r_inc[ROW_W-1:0];
                src_rbase_nxt = e_src_rbase + step_sy_r;
                src_row_nxt   = e_src_rbase + step_sy_r;
                dst_rbase_nxt = e_dst_rbase + step_ow_r;
                dst_row_nxt   = e_dst_rbase + step_ow_r;
              end else begin
                r_nxt         = '0;
                src_rbase_nxt = '0;
                src_row_nxt   = '0;
                dst_rbase_nxt = '0;
                dst_row_nxt   = '0;
              end
            end
          end
        end
      end
    end

    if (cfg_wr) seq_nxt = SEQ_SY;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seq_r <= SEQ_SY;
      r_r   <= '0;
      c_r   <= '0;
      kr_r  <= '0;
      kc_r  <= '0;
      d_r   <= '0;
      src_rbase_r <= '0;
      src_row_r   <= '0;
      src_col_r   <= '0;
      dst_rbase_r <= '0;
      dst_row_r   <= '0;
      dst_col_r   <= '0;
      kc_acc_r    <= '0;
      step_sy_r   <= '0;
      step_sx_r   <= '0;
      step_ow_r   <= '0;
      step_krp_r  <= '0;
    end else begin
      seq_r <= seq_nxt;
      r_r   <= r_nxt;
      c_r   <= c_nxt;
      kr_r  <= kr_nxt;
      kc_r  <= kc_nxt;
      d_r   <= d_nxt;
      src_rbase_r <= src_rbase_nxt;
      src_row_r   <= src_row_nxt;
      src_col_r   <= src_col_nxt;
      dst_rbase_r <= dst_rbase_nxt;
      dst_row_r   <= dst_row_nxt;
      dst_col_r   <= dst_col_nxt;
      kc_acc_r    <= kc_acc_nxt;
      step_sy_r   <= step_sy_nxt;
      step_sx_r   <= step_sx_nxt;
      step_ow_r   <= step_ow_nxt;
      step_krp_r  <= step_krp_nxt;
    end
  end

endmodule

// ----- design/i2c_queue.sv -----
// Short register queue between front and back.
`timescale 1ns / 1ps

module i2c_queue #(
  parameter int WIDTH = 8
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             wr,
  input  logic [WIDTH-1:0] wdata,
  output logic             full,
  input  logic             rd,
  output logic [WIDTH-1:0] rdata,
  output logic             empty
);
  import i2c_pkg::*;

  logic [WIDTH-1:0]  mem_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [QPTR_W:0]   count_r;

  assign full  = (count_r == (QPTR_W+1)'(QUEUE_DEPTH));
  assign empty = (count_r == '0);
  assign rdata = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (wr) mem_r[wr_ptr_r] <= wdata;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (wr) wr_ptr_r <= QPTR_W'(wr_ptr_r + 1'b1);
      if (rd) rd_ptr_r <= QPTR_W'(rd_ptr_r + 1'b1);
      // count holds when both or neither side moves
      if (wr && !rd)      count_r <= count_r + 1'b1;
      else if (rd && !wr) count_r <= count_r - 1'b1;
    end
  end

endmodule

// ----- design/i2c_back.sv -----
// Back end: two-stage offset adder pipeline ending in the output register.
`timescale 1ns / 1ps

module i2c_back #(
  parameter int AW = 32
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           q_empty,
  input  logic [5*AW+i2c_pkg::DIDX_W:0]  q_rdata,
  output logic                           q_rd,
  output logic                           out_empty,
  input  logic                           out_pop,
  output logic [i2c_pkg::OUT_OFF_W-1:0]  out_src_offset,
  output logic [i2c_pkg::OUT_OFF_W-1:0]  out_dst_offset,
  output logic                           out_last
);
  import i2c_pkg::*;

  logic [AW-1:0]     q_src_row, q_src_col, q_dst_row, q_dst_col, q_kc_acc;
  logic [DIDX_W-1:0] q_d;
  logic              q_last;

  logic          v1_r, v2_r, en1, en2;
  logic [AW-1:0] s1_r, d1_r, inner1_r;
  logic          last1_r, last2_r;
  logic [AW-1:0] src_r, dst_r;

  assign q_src_row = q_rdata[AW-1:0];
  assign q_src_col = q_rdata[2*AW-1:AW];
  assign q_dst_row = q_rdata[3*AW-1:2*AW];
  assign q_dst_col = q_rdata[4*AW-1:3*AW];
  assign q_kc_acc  = q_rdata[5*AW-1:4*AW];
  assign q_d       = q_rdata[5*AW+DIDX_W-1:5*AW];
  assign q_last    = q_rdata[5*AW+DIDX_W];

  assign en2  = !v2_r || out_pop;
  assign en1  = !v1_r || en2;
  assign q_rd = en1 && !q_empty;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else begin
      if (en1) v1_r <= !q_empty;
      if (en2) v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en1) begin
      s1_r     <= q_src_row + q_src_col;
      d1_r     <= q_dst_row + q_dst_col;
      inner1_r <= q_kc_acc + AW'({q_d, 2'b00});
      last1_r  <= q_last;
    end
    if (en2) begin
      src_r   <= s1_r + inner1_r;
      dst_r   <= d1_r + inner1_r;
      last2_r <= last1_r;
    end
  end

  assign out_empty      = !v2_r;
  assign out_src_offset = OUT_OFF_W'(src_r);
  assign out_dst_offset = OUT_OFF_W'(dst_r);
  assign out_last       = last2_r;

endmodule

// ----- design/im2col_address_generator_unit.sv -----
// Top level of the im2col address generator.
//
//  channel | ports                                   | beat moves on
//  --------+-----------------------------------------+---------------------------
//  in      | in_push, in_full, in_restart            | in_push & !in_full
//  out     | out_empty, out_pop, out_src/dst_offset, | out_pop & !out_empty
//          | out_last                                |
//  cfg     | cfg_valid, cfg_ready, cfg_index, cfg_data | cfg_valid & cfg_ready
//
// One beat in, one offset pair out; a new beat can be taken every cycle while
// in_full is low. A result passes the queue and both adder stages to the out port.
// After reset and after every cfg write the front runs a rebuild
// pass through its one shared multiplier; in_full stays high while it runs.
// Reset is synchronous, active low; cfg_ready is always high.
// A stalled out port backs up the adder stages, then the queue, then in_full.
`timescale 1ns / 1ps

module im2col_address_generator_unit #(
  parameter int OFFSET_BITS = 32
) (
  input  logic                            clk,
  input  logic                            rst_n,
  // input beats
  input  logic                            in_push,
  output logic                            in_full,
  input  logic                            in_restart,
  // result beats
  output logic                            out_empty,
  input  logic                            out_pop,
  output logic [i2c_pkg::OUT_OFF_W-1:0]   out_src_offset,
  output logic [i2c_pkg::OUT_OFF_W-1:0]   out_dst_offset,
  output logic                            out_last,
  // register writes
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [i2c_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [i2c_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import i2c_pkg::*;

  // offsets wrap at OFFSET_BITS and are then cut to the 32-bit ports,
  // so the datapath only needs the narrower of the two
  localparam int AW      = (OFFSET_BITS < OUT_OFF_W) ? OFFSET_BITS : OUT_OFF_W;
  localparam int ENTRY_W = 5*AW + DIDX_W + 1;

  cfg_t               cfg;
  logic               cfg_wr;
  logic               q_wr, q_rd, q_full, q_empty;
  logic [ENTRY_W-1:0] q_wdata, q_rdata;

  i2c_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg),
    .cfg_wr    (cfg_wr)
  );

  // front: counters plus running offset terms, one beat per cycle while in_full is low
  i2c_front #(.AW(AW)) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg),
    .cfg_wr     (cfg_wr),
    .in_push    (in_push),
    .in_restart (in_restart),
    .in_full    (in_full),
    .q_full     (q_full),
    .q_wr       (q_wr),
    .q_wdata    (q_wdata)
  );

  i2c_queue #(.WIDTH(ENTRY_W)) u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .wr    (q_wr),
    .wdata (q_wdata),
    .full  (q_full),
    .rd    (q_rd),
    .rdata (q_rdata),
    .empty (q_empty)
  );

  // back: sums the terms into the two offsets
  i2c_back #(.AW(AW)) u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .q_empty        (q_empty),
    .q_rdata        (q_rdata),
    .q_rd           (q_rd),
    .out_empty      (out_empty),
    .out_pop        (out_pop),
    .out_src_offset (out_src_offset),
    .out_dst_offset (out_dst_offset),
    .out_last       (out_last)
  );

endmodule

// ----- design/i2c_chk.sv -----
// Port-level checker for the im2col address generator, bound to the top level.
`timescale 1ns / 1ps
`include "im2col_address_generator_unit_assert.svh"

module i2c_chk (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            in_full,
  input logic                            out_empty,
  input logic                            out_pop,
  input logic [i2c_pkg::OUT_OFF_W-1:0]   out_src_offset,
  input logic [i2c_pkg::OUT_OFF_W-1:0]   out_dst_offset,
  input logic                            out_last,
  input logic                            cfg_valid,
  input logic                            cfg_ready
);

  // a waiting result holds until popped
  `IAGU_CHECK_NEXT(a_out_hold, !out_empty && !out_pop, !out_empty && $stable(out_src_offset) && $stable(out_dst_offset) && $stable(out_last))

  // a register write starts the rebuild pass, which blocks input
  `IAGU_CHECK_NEXT(a_cfg_blocks, cfg_valid && cfg_ready, in_full)

  // rebuild is still running at its SEQ_SX step after a write
  `IAGU_CHECK(a_cfg_blocks_two, cfg_valid && cfg_ready, ##2 in_full)

  // leaving reset: nothing to pop, rebuild in progress
  `IAGU_CHECK(a_reset_exit, $past(!rst_n), in_full && out_empty)

endmodule

bind im2col_address_generator_unit i2c_chk u_i2c_chk (.*);

// ----- sim/im2col_address_generator_unit_checker.sv -----
// Beat monitor, offset predictor and result scoreboard for the im2col address generator.
`timescale 1ns / 1ps

module im2col_address_generator_unit_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_push,
  input  logic        in_full,
  input  logic        in_restart,
  input  logic        out_empty,
  input  logic        out_pop,
  input  logic [31:0] out_src_offset,
  input  logic [31:0] out_dst_offset,
  input  logic        out_last,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data,
  output int          mismatches,
  output int          outstanding
);
  import i2c_pkg::*;

  typedef struct packed {
    logic [31:0] src;
    logic [31:0] dst;
    logic        last;
  } addr_pair_t;

  // shadow registers
  logic [8:0]  depth_vecs;
  logic [6:0]  kernel_w;
  logic [6:0]  kernel_h;
  logic [15:0] kernel_row_pitch;
  logic [31:0] src_row_pitch;
  logic [31:0] dst_row_pitch;
  logic [31:0] out_dims;
  logic [15:0] strides;

  // next position
  logic [15:0] out_row;
  logic [15:0] out_col;
  logic [5:0]  ker_row;
  logic [5:0]  ker_col;
  logic [7:0]  depth_idx;

  addr_pair_t pending_pairs[$];

  initial begin
    mismatches  = 0;
    outstanding = 0;
  end

  function automatic int unsigned count_of(int unsigned v, int unsigned hi);
    return (v == 32'd0) ? 32'd1 : ((v > hi) ? hi : v);
  endfunction

  function automatic bit at_bound(int unsigned cur, int unsigned bound);
    return (cur + 32'd1) >= bound;
  endfunction

  function automatic addr_pair_t next_addr_pair(logic restart);
    int unsigned dv, kw, kh, ow, oh;
    logic [63:0] sx, sy, pix, r, kr, c, kc, d, src_pos, dst_pos, full_src, full_dst;
    addr_pair_t p;
    dv  = count_of(32'(depth_vecs), 32'(DV_MAX));
    kw  = count_of(32'(kernel_w), 32'(KER_MAX));
    kh  = count_of(32'(kernel_h), 32'(KER_MAX));
    ow  = count_of(32'(out_dims[15:0]), 32'h0000_FFFF);
    oh  = count_of(32'(out_dims[31:16]), 32'h0000_FFFF);
    sx  = 64'(strides[7:0]);
    sy  = 64'(strides[15:8]);
    pix = 64'(dv) * 64'd4;
    if (restart) begin
      out_row   = '0;
      out_col   = '0;
      ker_row   = '0;
      ker_col   = '0;
      depth_idx = '0;
    end
    r  = 64'(out_row);
    kr = 64'(ker_row);
    c  = 64'(out_col);
    kc = 64'(ker_col);
    d  = 64'(depth_idx);
    // 64-bit sums; only the low 32 bits matter
    src_pos  = r * sy * 64'(src_row_pitch) + kr * 64'(src_row_pitch) + c * sx * pix;
    dst_pos  = r * 64'(ow) * 64'(dst_row_pitch) + kr * 64'(kernel_row_pitch) * pix
               + c * 64'(dst_row_pitch);
    full_src = src_pos + kc * pix + d * 64'd4;
    full_dst = dst_pos + kc * pix + d * 64'd4;
    p.src  = full_src[31:0];
    p.dst  = full_dst[31:0];
    p.last = (r == 64'(oh - 32'd1)) && (kr == 64'(kh - 32'd1)) && (c == 64'(ow - 32'd1))
             && (kc == 64'(kw - 32'd1)) && (d == 64'(dv - 32'd1));
    // innermost first; a counter past a shrunken bound wraps with a carry
    if (at_bound(32'(depth_idx), dv)) begin
      depth_idx = '0;
      if (at_bound(32'(ker_col), kw)) begin
        ker_col = '0;
        if (at_bound(32'(out_col), ow)) begin
          out_col = '0;
          if (at_bound(32'(ker_row), kh)) begin
            ker_row = '0;
            if (at_bound(32'(out_row), oh)) out_row = '0;
            else out_row = out_row + 1'b1;
          end else ker_row = ker_row + 1'b1;
        end else out_col = out_col + 1'b1;
      end else ker_col = ker_col + 1'b1;
    end else depth_idx = depth_idx + 1'b1;
    return p;
  endfunction

  task automatic report_mismatch(string field, logic [31:0] got, logic [31:0] want);
    $display("%0t: mismatch on %s: got %h, expected %h", $time, field, got, want);
    mismatches++;
  endtask

  always @(posedge clk) begin : watch_beats
    addr_pair_t want;
    if (!rst_n) begin
      depth_vecs       = RST_DEPTH_VECS;
      kernel_w         = RST_KERNEL_W;
      kernel_h         = RST_KERNEL_H;
      kernel_row_pitch = RST_KRP;
      src_row_pitch    = RST_SRP;
      dst_row_pitch    = RST_DRP;
      out_dims         = RST_OUT_DIMS;
      strides          = RST_STRIDES;
      out_row          = '0;
      out_col          = '0;
      ker_row          = '0;
      ker_col          = '0;
      depth_idx        = '0;
      pending_pairs.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (reg_idx_t'(cfg_index))
          REG_DEPTH_VECS:       depth_vecs       = cfg_data[8:0];
          REG_KERNEL_W:         kernel_w         = cfg_data[6:0];
          REG_KERNEL_H:         kernel_h         = cfg_data[6:0];
          REG_KERNEL_ROW_PITCH: kernel_row_pitch = cfg_data[15:0];
          REG_SRC_ROW_PITCH:    src_row_pitch    = cfg_data;
          REG_DST_ROW_PITCH:    dst_row_pitch    = cfg_data;
          REG_OUT_DIMS:         out_dims         = cfg_data;
          REG_STRIDES:          strides          = cfg_data[15:0];
          default: ;
        endcase
      end
      // results first: a beat taken this edge cannot come out at the same edge
      if (out_pop && !out_empty) begin
        if (pending_pairs.size() == 0) begin
          report_mismatch("result beat with nothing expected", out_src_offset, 32'd0);
        end else begin
          want = pending_pairs.pop_front();
          if (out_src_offset !== want.src)
            report_mismatch("src_offset", out_src_offset, want.src);
          if (out_dst_offset !== want.dst)
            report_mismatch("dst_offset", out_dst_offset, want.dst);
          if (out_last !== want.last)
            report_mismatch("last", {31'd0, out_last}, {31'd0, want.last});
        end
      end
      if (in_push && !in_full) pending_pairs.push_back(next_addr_pair(in_restart));
    end
    outstanding <= pending_pairs.size();
  end

endmodule

// ----- sim/im2col_address_generator_unit_tb.sv -----
// Stimulus, flow control and verdict for the im2col address generator.
`timescale 1ns / 1ps

module im2col_address_generator_unit_tb;
  import i2c_pkg::*;

  localparam int TARGET_ITEMS = 650;
  localparam int IDLE_PCT     = 23;   // chance per cycle that a side idles
  localparam int RESTART_PCT  = 6;
  localparam int HOLD_CYCLES  = 64;   // long receiver hold-off, fills the pipe
  localparam int DRAIN_CYCLES = 16;   // covers the output pipeline and the rebuild pass, with margin
  localparam int QUIET_LIMIT  = 4000; // cycles with no beat at all before giving up

  logic                  clk;
  logic                  rst_n;
  logic                  in_push;
  logic                  in_full;
  logic                  in_restart;
  logic                  out_empty;
  logic                  out_pop;
  logic [OUT_OFF_W-1:0]  out_src_offset;
  logic [OUT_OFF_W-1:0]  out_dst_offset;
  logic                  out_last;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  int mismatches;
  int outstanding;
  int items_sent;
  int quiet_cycles;
  int hold_left;
  bit steady;     // no idling on either side while set
  bit hold_req;   // toggled by stimulus to ask for one long hold-off
  bit hold_ack;

  im2col_address_generator_unit i_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_push        (in_push),
    .in_full        (in_full),
    .in_restart     (in_restart),
    .out_empty      (out_empty),
    .out_pop        (out_pop),
    .out_src_offset (out_src_offset),
    .out_dst_offset (out_dst_offset),
    .out_last       (out_last),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data)
  );

  im2col_address_generator_unit_checker i_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_push        (in_push),
    .in_full        (in_full),
    .in_restart     (in_restart),
    .out_empty      (out_empty),
    .out_pop        (out_pop),
    .out_src_offset (out_src_offset),
    .out_dst_offset (out_dst_offset),
    .out_last       (out_last),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .mismatches     (mismatches),
    .outstanding    (outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Watchdog: any beat on any channel resets the quiet count.
  always @(posedge clk) begin
    if (!rst_n || (in_push && !in_full) || (out_pop && !out_empty) || (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == QUIET_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Receiver: random pops, plus one long hold-off counted here so the
  // queue backs up and in_full rises while the sender keeps offering.
  initial begin
    out_pop   = 1'b0;
    hold_left = 0;
    forever begin
      @(negedge clk);
      if (hold_req != hold_ack) begin
        hold_ack  = hold_req;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        out_pop   <= 1'b0;
        hold_left--;
      end else begin
        out_pop <= steady || ($urandom_range(0, 99) >= IDLE_PCT);
      end
    end
  end

  // One input beat; enters and leaves at a falling edge. in_push stays
  // high on return so back-to-back beats need no lowering in between.
  task automatic push_beat(bit restart);
    while (!steady && $urandom_range(0, 99) < IDLE_PCT) begin
      in_push    <= 1'b0;
      in_restart <= 1'($urandom_range(0, 1));
      @(negedge clk);
    end
    in_push    <= 1'b1;
    in_restart <= restart;
    do @(posedge clk); while (in_full !== 1'b0);
    items_sent++;
    @(negedge clk);
  endtask

  // Register write beat; cfg_valid is left high for a following write.
  task automatic write_reg(reg_idx_t idx, logic [31:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (cfg_ready !== 1'b1);
    @(negedge clk);
  endtask

  // Stop offering, wait for every expected result, then let the pipe settle.
  task automatic drain();
    in_push <= 1'b0;
    while (outstanding != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  // Mostly small job shapes so that wraps and last beats come often;
  // now and then the full field. Bits above a field's width are junk.
  function automatic logic [31:0] pick_reg_value(reg_idx_t idx);
    bit wide;
    logic [31:0] field, keep;
    wide = ($urandom_range(0, 9) == 0);
    case (idx)
      REG_DEPTH_VECS: begin
        keep  = 32'h0000_01FF;
        field = wide ? $urandom_range(0, 511) : $urandom_range(0, 4);
      end
      REG_KERNEL_W, REG_KERNEL_H: begin
        keep  = 32'h0000_007F;
        field = wide ? $urandom_range(0, 127) : $urandom_range(0, 3);
      end
      REG_KERNEL_ROW_PITCH: begin
        keep  = 32'h0000_FFFF;
        field = wide ? $urandom_range(0, 65535) : $urandom_range(0, 8);
      end
      REG_OUT_DIMS: begin
        keep  = 32'hFFFF_FFFF;
        field = wide ? $urandom : {16'($urandom_range(0, 2)), 16'($urandom_range(0, 3))};
      end
      REG_STRIDES: begin
        keep  = 32'h0000_FFFF;
        field = wide ? $urandom_range(0, 65535)
                     : {16'd0, 8'($urandom_range(0, 3)), 8'($urandom_range(0, 3))};
      end
      default: begin
        keep  = 32'hFFFF_FFFF;
        field = wide ? $urandom : $urandom_range(0, 4096);
      end
    endcase
    return ($urandom & ~keep) | (field & keep);
  endfunction

  initial begin
    int phase;
    int n;
    rst_n      = 1'b0;
    in_push    = 1'b0;
    in_restart = 1'b0;
    cfg_valid  = 1'b0;
    cfg_index  = REG_DEPTH_VECS;
    cfg_data   = '0;
    steady     = 1'b0;
    hold_req   = 1'b0;
    hold_ack   = 1'b0;
    items_sent = 0;
    repeat (8) @(negedge clk);
    rst_n <= 1'b1;

    // reset shape: one-vector job, every beat is last
    push_beat(1'b0);
    push_beat(1'b1);
    push_beat(1'b0);
    drain();

    // zero counts read as one, zero strides hold the position
    write_reg(REG_DEPTH_VECS,       32'hFFFF_FE00);
    write_reg(REG_KERNEL_W,         32'h0000_0000);
    write_reg(REG_KERNEL_H,         32'hFFFF_FF80);
    write_reg(REG_KERNEL_ROW_PITCH, 32'h0000_FFFF);
    write_reg(REG_SRC_ROW_PITCH,    32'hFFFF_FFFF);
    write_reg(REG_DST_ROW_PITCH,    32'hFFFF_FFFF);
    write_reg(REG_OUT_DIMS,         32'h0000_0000);
    write_reg(REG_STRIDES,          32'h0000_0000);
    cfg_valid <= 1'b0;
    push_beat(1'b0);
    push_beat(1'b0);
    push_beat(1'b1);
    drain();

    // oversized counts clamp, the rest but the source row pitch at its top, offsets wrap
    write_reg(REG_DEPTH_VECS,       32'h0000_01FF);
    write_reg(REG_KERNEL_W,         32'h0000_007F);
    write_reg(REG_KERNEL_H,         32'h0000_007F);
    write_reg(REG_KERNEL_ROW_PITCH, 32'hFFFF_FFFF);
    write_reg(REG_SRC_ROW_PITCH,    32'h8000_0001);
    write_reg(REG_DST_ROW_PITCH,    32'hFFFF_FFFF);
    write_reg(REG_OUT_DIMS,         32'hFFFF_FFFF);
    write_reg(REG_STRIDES,          32'hFFFF_FFFF);
    cfg_valid <= 1'b0;
    push_beat(1'b1);
    repeat (5) push_beat(1'b0);
    drain();

    // shrink mid-job: depth counter is past its new bound, then a full job
    write_reg(REG_DEPTH_VECS,       32'd2);
    write_reg(REG_KERNEL_W,         32'd2);
    write_reg(REG_KERNEL_H,         32'd1);
    write_reg(REG_KERNEL_ROW_PITCH, 32'd3);
    write_reg(REG_SRC_ROW_PITCH,    32'd100);
    write_reg(REG_DST_ROW_PITCH,    32'd64);
    write_reg(REG_OUT_DIMS,         32'h0001_0002);
    write_reg(REG_STRIDES,          32'h0000_0201);
    cfg_valid <= 1'b0;
    repeat (8) push_beat(1'b0);
    push_beat(1'b1);
    repeat (3) push_beat(1'b0);
    drain();

    // random phases; shapes change without restart too
    phase = 0;
    while (items_sent < TARGET_ITEMS) begin
      for (int i = REG_DEPTH_VECS; i <= REG_STRIDES; i++) begin
        if (phase == 0 || $urandom_range(0, 1) == 1)
          write_reg(reg_idx_t'(i), pick_reg_value(reg_idx_t'(i)));
      end
      cfg_valid <= 1'b0;
      steady = (phase == 3);
      if (phase == 1) hold_req = ~hold_req;
      n = (phase == 1) ? 60 : $urandom_range(20, 70);
      repeat (n) push_beat($urandom_range(0, 99) < RESTART_PCT);
      drain();
      phase++;
    end

    if (mismatches == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
+incdir+design
design/i2c_pkg.sv
design/i2c_cfg.sv
design/i2c_front.sv
design/i2c_queue.sv
design/i2c_back.sv
design/im2col_address_generator_unit.sv
design/i2c_chk.sv
sim/im2col_address_generator_unit_checker.sv
sim/im2col_address_generator_unit_tb.sv
